>>> hdl/skvt_pkg.sv
// Package: payload types, op and status codes for the sorted key/value table.
`timescale 1ns / 1ps
package skvt_pkg;
   localparam int CAPACITY  = 64;
   localparam int KEY_BYTES = 8;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = 7;
   localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - 8 * KEY_BYTES);

   typedef enum logic [2:0] {
      OP_ADD = 3'd0, OP_FIND = 3'd1, OP_DELETE = 3'd2, OP_PREFIX = 3'd3, OP_LIST = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_NOTFOUND = 2'd1, ST_FULL = 2'd2, ST_NOPREFIX = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [63:0] name_key;
      logic [3:0]  prefix_len;
      logic [63:0] phone_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] entry_key;
      logic [63:0] entry_value;
      logic [6:0]  match_total;
      logic [6:0]  entries_held;
      logic        last;
   } rsp_type;
endpackage

>>> hdl/sorted_key_value_table.sv
// Top level: sorted key/value table with add, find, delete, prefix find and list.
//
// Usage: requests arrive on req_valid/req_ready/req_data, results leave on
// rsp_valid/rsp_ready/rsp_data, both valid/ready with a transfer when both high.
// One request is worked at a time. Keys and values live in one synchronous
// memory of CAPACITY words (key and value side by side) with a registered read.
// Each entry visited takes an address step, then a compare step. find: scans
// in order and answers at the first match, or with not-found after the last
// entry. delete: as find, then reads and shifts each later entry down by one
// and finishes by lowering the count. add: shifts each larger entry up by
// one, then writes the new one. list: one result per entry. prefix find: one
// result per match, with the last match flagged as last.
// A stalled receiver holds the result register and freezes the scan; results
// are never dropped. The next request is taken the cycle after the last result
// of the current run has been transferred. Reset empties the table (count to
// zero); memory contents are undefined until written.
`timescale 1ns / 1ps
module sorted_key_value_table
   import skvt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,
      S_CHECK = 7'b0000100,
      S_SHUP  = 7'b0001000,
      S_SHDN  = 7'b0010000,
      S_PUT   = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   logic [127:0] mem [CAPACITY];
   logic [127:0] rd_data_ff;

   state_type   state_ff, state_in;
   req_type     req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        found_ff, found_in;

   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [127:0]     wr_data;

   logic [63:0] key_m, rk, rv, pmask;
   logic [3:0]  plen;
   logic        hit;

   always_comb begin
      key_m = req_ff.name_key & KEY_MASK;
      rk    = rd_data_ff[127:64];
      rv    = rd_data_ff[63:0];
      plen  = (req_ff.prefix_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : req_ff.prefix_len;
      pmask = (plen == 4'd0) ? 64'd0 : (KEY_MASK >> (8 * (4'(KEY_BYTES) - plen)))
              << (8 * (4'(KEY_BYTES) - plen));
      hit   = ((rk ^ key_m) & pmask) == 64'd0;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      total_in     = total_ff;
      found_in     = found_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff[IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = ptr_ff[IDX_W-1:0];
      wr_data      = {key_m, req_ff.phone_value};
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = !rsp_valid_ff;
            if (req_valid && !rsp_valid_ff) begin
               req_in   = req_data;
               total_in = '0;
               found_in = 1'b0;
               case (req_data.op)
                  OP_ADD: begin
                     ptr_in = count_ff;
                     state_in = (count_ff >= CNT_W'(CAPACITY)) ? S_OUT : S_SHUP;
                  end
                  OP_FIND, OP_DELETE, OP_PREFIX, OP_LIST: begin
                     ptr_in = '0;
                     state_in = S_SCAN;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            if (ptr_ff >= count_ff) begin
               state_in = S_OUT;
            end else begin
               rd_en    = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_SCAN;
               ptr_in   = ptr_ff + 1'b1;
               case (req_ff.op)
                  OP_FIND, OP_DELETE: begin
                     if (rk == key_m) begin
                        rsp_in = '{ST_OK, rk, rv, 7'd1, count_ff, 1'b1};
                        if (req_ff.op == OP_DELETE) begin
                           rsp_in.entries_held = count_ff - 1'b1;
                           state_in = S_SHDN;
                        end else begin
                           found_in = 1'b1;
                           rsp_valid_in = 1'b1;
                           state_in = S_IDLE;
                        end
                     end
                  end
                  OP_PREFIX: begin
                     if (hit && found_ff) begin
                        rsp_valid_in = 1'b1;
                        found_in     = 1'b0;
                        ptr_in       = ptr_ff;
                        state_in     = S_CHECK;
                     end else if (hit) begin
                        found_in = 1'b1;
                        total_in = total_ff + 1'b1;
                        rsp_in   = '{ST_OK, rk, rv, total_ff + 1'b1, count_ff, 1'b0};
                     end
                  end
                  default: begin
                     total_in = total_ff + 1'b1;
                     rsp_in = '{ST_OK, rk, rv, total_ff + 1'b1, count_ff,
                                ptr_ff + 1'b1 >= count_ff};
                     rsp_valid_in = 1'b1;
                  end
               endcase
               if (ptr_ff + 1'b1 >= count_ff && req_ff.op == OP_LIST)
                  state_in = S_IDLE;
            end
         end
         S_SHDN: begin
            if (ptr_ff >= count_ff) begin
               count_in     = count_ff - 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (!found_ff) begin
               rd_en    = 1'b1;
               found_in = 1'b1;
            end else begin
               wr_en   = 1'b1;
               wr_addr = 6'(ptr_ff - 1'b1);
               wr_data = rd_data_ff;
               rd_en   = (ptr_ff + 1'b1 < count_ff);
               rd_addr = 6'(ptr_ff + 1'b1);
               ptr_in  = ptr_ff + 1'b1;
               if (!rd_en) found_in = 1'b1;
            end
         end
         S_SHUP: begin
            if (ptr_ff == '0) begin
               state_in = S_PUT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = 6'(ptr_ff - 1'b1);
               state_in = S_PUT;
               found_in = 1'b1;
            end
         end
         S_PUT: begin
            if (found_ff && rk > key_m) begin
               wr_en    = 1'b1;
               wr_data  = rd_data_ff;
               ptr_in   = ptr_ff - 1'b1;
               found_in = 1'b0;
               state_in = S_SHUP;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               rsp_in   = '{ST_OK, key_m, req_ff.phone_value, 7'd0, count_ff + 1'b1, 1'b1};
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               case (req_ff.op)
                  OP_ADD:    rsp_in = '{ST_FULL, key_m, req_ff.phone_value, 7'd0,
                                        count_ff, 1'b1};
                  OP_PREFIX: begin
                     if (found_ff) begin
                        rsp_in      = rsp_ff;
                        rsp_in.last = 1'b1;
                     end else begin
                        rsp_in = '{ST_NOPREFIX, key_m, 64'd0, 7'd0, count_ff, 1'b1};
                     end
                  end
                  OP_LIST:   rsp_in = '{ST_NOTFOUND, 64'd0, 64'd0, 7'd0, count_ff, 1'b1};
                  default:   rsp_in = '{ST_NOTFOUND, key_m, 64'd0, 7'd0, count_ff, 1'b1};
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         total_ff     <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
         total_ff     <= total_in;
         found_ff     <= found_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY)) else $error("entry count above capacity");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result changed while stalled");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE && !rsp_valid_ff) else $error("ready while busy");
endmodule

>>> tb/tb_top.sv
// Testbench for the sorted key/value table: directed table plus random traffic, scoreboarded.
`timescale 1ns / 1ps
module tb_top;
   import skvt_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   sorted_key_value_table u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   logic [63:0] table_keys [$];
   logic [63:0] table_vals [$];
   rsp_type     expected_rsps [$];
   int          error_count = 0;
   int          rsp_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          adds_full = 0;
   int          prefix_runs = 0;

   function automatic rsp_type make_rsp(status_type st, logic [63:0] k, logic [63:0] v,
                                        int total, logic fin);
      rsp_type r;
      r.status = st;
      r.entry_key = k;
      r.entry_value = v;
      r.match_total = total[6:0];
      r.entries_held = 7'(table_keys.size());
      r.last = fin;
      return r;
   endfunction

   task automatic predict_table_op(req_type rq);
      logic [63:0] k;
      int plen;
      int pos;
      int hits;
      logic [63:0] fk;
      logic [63:0] fv;
      k = rq.name_key & KEY_MASK;
      pos = -1;
      hits = 0;
      case (rq.op)
         OP_ADD: begin
            if (table_keys.size() >= CAPACITY) begin
               adds_full++;
               expected_rsps.push_back(make_rsp(ST_FULL, k, rq.phone_value, 0, 1'b1));
            end else begin
               pos = table_keys.size();
               while (pos > 0 && table_keys[pos-1] > k) pos--;
               table_keys.insert(pos, k);
               table_vals.insert(pos, rq.phone_value);
               expected_rsps.push_back(make_rsp(ST_OK, k, rq.phone_value, 0, 1'b1));
            end
         end
         OP_FIND, OP_DELETE: begin
            foreach (table_keys[i]) if (pos < 0 && table_keys[i] == k) pos = i;
            if (pos < 0) begin
               expected_rsps.push_back(make_rsp(ST_NOTFOUND, k, 64'd0, 0, 1'b1));
            end else begin
               fk = table_keys[pos];
               fv = table_vals[pos];
               if (rq.op == OP_DELETE) begin
                  table_keys.delete(pos);
                  table_vals.delete(pos);
               end
               expected_rsps.push_back(make_rsp(ST_OK, fk, fv, 1, 1'b1));
            end
         end
         OP_PREFIX: begin
            prefix_runs++;
            plen = (rq.prefix_len > KEY_BYTES) ? KEY_BYTES : rq.prefix_len;
            foreach (table_keys[i]) begin
               if (plen == 0 || ((table_keys[i] ^ k) >> (8 * (KEY_BYTES - plen))) == 0) begin
                  hits++;
                  expected_rsps.push_back(make_rsp(ST_OK, table_keys[i], table_vals[i],
                                                   hits, 1'b0));
               end
            end
            if (hits == 0) expected_rsps.push_back(make_rsp(ST_NOPREFIX, k, 64'd0, 0, 1'b1));
            else expected_rsps[$].last = 1'b1;
         end
         OP_LIST: begin
            if (table_keys.size() == 0) begin
               expected_rsps.push_back(make_rsp(ST_NOTFOUND, 64'd0, 64'd0, 0, 1'b1));
            end else begin
               foreach (table_keys[i])
                  expected_rsps.push_back(make_rsp(ST_OK, table_keys[i], table_vals[i], i + 1,
                                                   i + 1 == table_keys.size()));
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_request(req_type rq);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) @(posedge clock);
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_table_op(rq);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      while (expected_rsps.size() > 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected transfer, actual %p", $time, rsp_data);
               error_count++;
            end else begin
               if (rsp_data !== expected_rsps[0]) begin
                  $display("%0t: mismatch, expected %p, actual %p", $time,
                           expected_rsps[0], rsp_data);
                  error_count++;
               end
               void'(expected_rsps.pop_front());
            end
         end
         rsp_ready <= (recv_stall_pct == 0) || ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   function automatic req_type make_req(op_type op, logic [63:0] k, logic [3:0] plen,
                                        logic [63:0] v);
      req_type r;
      r.op = op;
      r.name_key = k;
      r.prefix_len = plen;
      r.phone_value = v;
      return r;
   endfunction

   function automatic logic [63:0] ascii_key(int n);
      logic [63:0] k;
      k = '0;
      for (int b = 0; b < n; b++) k[63 - 8*b -: 8] = 8'(8'h61 + $urandom_range(2, 0));
      return k;
   endfunction

   req_type directed_rows [$];
   rsp_type directed_expect [$];

   initial begin
      req_type rq;
      int phase;
      int pick;
      logic [63:0] k;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows; the first ones carry a typed-in expectation
      directed_rows.push_back(make_req(OP_LIST, 64'h0, 4'd0, 64'h0));
      directed_expect.push_back('{ST_NOTFOUND, 64'h0, 64'h0, 7'd0, 7'd0, 1'b1});
      directed_rows.push_back(make_req(OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 64'h0));
      directed_expect.push_back('{ST_NOTFOUND, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 7'd0, 7'd0,
                                  1'b1});
      directed_rows.push_back(make_req(OP_DELETE, 64'h0, 4'd0, 64'h0));
      directed_expect.push_back('{ST_NOTFOUND, 64'h0, 64'h0, 7'd0, 7'd0, 1'b1});
      directed_rows.push_back(make_req(OP_PREFIX, 64'h6100_0000_0000_0000, 4'd1, 64'h0));
      directed_expect.push_back('{ST_NOPREFIX, 64'h6100_0000_0000_0000, 64'h0, 7'd0, 7'd0,
                                  1'b1});
      directed_rows.push_back(make_req(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF,
                                       64'hFFFF_FFFF_FFFF_FFFF));
      directed_expect.push_back('{ST_OK, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                  7'd0, 7'd1, 1'b1});
      directed_rows.push_back(make_req(OP_ADD, 64'h0, 4'd0, 64'h0));
      directed_expect.push_back('{ST_OK, 64'h0, 64'h0, 7'd0, 7'd2, 1'b1});
      directed_rows.push_back(make_req(OP_ADD, 64'h6162_0000_0000_0000, 4'd0, 64'h1));
      directed_rows.push_back(make_req(OP_ADD, 64'h6162_0000_0000_0000, 4'd0, 64'h2));
      directed_rows.push_back(make_req(OP_ADD, 64'h6163_0000_0000_0000, 4'd0, 64'h3));
      directed_rows.push_back(make_req(op_type'(3'd5), 64'h1, 4'd1, 64'h1));
      directed_rows.push_back(make_req(op_type'(3'd7), 64'h2, 4'd2, 64'h2));
      directed_rows.push_back(make_req(OP_FIND, 64'h6162_0000_0000_0000, 4'd0, 64'h0));
      directed_rows.push_back(make_req(OP_PREFIX, 64'h6100_0000_0000_0000, 4'd1, 64'h0));
      directed_rows.push_back(make_req(OP_PREFIX, 64'h6162_0000_0000_0000, 4'd15, 64'h0));
      directed_rows.push_back(make_req(OP_PREFIX, 64'h1234_0000_0000_0000, 4'd0, 64'h0));
      directed_rows.push_back(make_req(OP_PREFIX, 64'h1234_0000_0000_0000, 4'd8, 64'h0));
      directed_rows.push_back(make_req(OP_LIST, 64'h0, 4'd0, 64'h0));
      directed_rows.push_back(make_req(OP_DELETE, 64'h6162_0000_0000_0000, 4'd0, 64'h0));
      directed_rows.push_back(make_req(OP_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 64'h0));
      directed_rows.push_back(make_req(OP_LIST, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 64'h0));
      foreach (directed_rows[i]) begin
         if (i < directed_expect.size()) begin
            send_request(directed_rows[i]);
            drain_results();
            // wait out each typed-in row before the next
         end else begin
            send_request(directed_rows[i]);
         end
      end
      drain_results();
      if (1) begin
         // cross-check the literal rows against the predictor outputs
         table_keys.delete();
         table_vals.delete();
         foreach (directed_expect[i]) begin
            predict_table_op(directed_rows[i]);
            if (expected_rsps[0] !== directed_expect[i]) begin
               $display("%0t: table row %0d, expected %p, actual %p", $time, i,
                        directed_expect[i], expected_rsps[0]);
               error_count++;
            end
            void'(expected_rsps.pop_front());
         end
         expected_rsps.delete();
         // restore model state by replaying the remaining directed rows
         for (int i = directed_expect.size(); i < directed_rows.size(); i++)
            predict_table_op(directed_rows[i]);
         expected_rsps.delete();
      end

      // fill to capacity so the full case is reached
      while (table_keys.size() < CAPACITY)
         send_request(make_req(OP_ADD, ascii_key($urandom_range(8, 1)), 4'd0,
                               {$urandom, $urandom}));
      send_request(make_req(OP_ADD, {$urandom, $urandom}, 4'd0, {$urandom, $urandom}));
      send_request(make_req(OP_LIST, 64'h0, 4'd0, 64'h0));
      drain_results();
      while (table_keys.size() > 24)
         send_request(make_req(OP_DELETE, table_keys[$urandom_range(table_keys.size()-1, 0)],
                               4'd0, 64'h0));

      for (int n = 0; n < 96; n++) begin
         phase = n / 24;
         send_idle_pct = (phase == 1 || phase == 3) ? 56 : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 7 : 56) : 0;
         if (phase == 3) send_idle_pct = 7;
         if (n == 48) drain_results();
         pick = $urandom_range(99, 0);
         k = ascii_key($urandom_range(8, 1));
         if (pick < 8) k = {$urandom, $urandom};
         if (table_keys.size() > 0 && $urandom_range(1, 0))
            k = table_keys[$urandom_range(table_keys.size() - 1, 0)];
         if (pick < 35 && table_keys.size() < 24)      rq = make_req(OP_ADD, k, 4'd0, 64'h0);
         else if (pick < 50) rq = make_req(OP_FIND, k, 4'd0, 64'h0);
         else if (pick < 68) rq = make_req(OP_DELETE, k, 4'd0, 64'h0);
         else if (pick < 88) rq = make_req(OP_PREFIX, k, 4'd0, 64'h0);
         else if (pick < 96) rq = make_req(OP_LIST, k, 4'd0, 64'h0);
         else                rq = make_req(op_type'(3'($urandom_range(7, 5))), k, 4'd0, 64'h0);
         rq.prefix_len = 4'($urandom_range(15, 0));
         rq.phone_value = {$urandom, $urandom};
         send_request(rq);
      end
      send_idle_pct = 0;
      drain_results();
      repeat (80) @(posedge clock);
      $display("Covered %0d result transfers over add, find, delete, prefix and list,",
               rsp_count);
      $display("with %0d full-table adds and %0d prefix runs under idle and stall mixes.",
               adds_full, prefix_runs);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
